/* hw/rtl/mtg_pkg.sv */
// Shared types, constants and word functions for the Mersenne Twister block.
// No dependencies; imported by mersenne_twister_generator and its bench.
`default_nettype none

package mtg_pkg;

    localparam int unsigned STATE_WORDS  = 624;
    localparam int unsigned SHIFT_OFFSET = 397;
    localparam int unsigned IDX_W        = $clog2(STATE_WORDS);

    localparam logic [IDX_W-1:0] IDX_LAST  = IDX_W'(STATE_WORDS - 1);
    localparam logic [IDX_W-1:0] FAR_OFS   = IDX_W'(SHIFT_OFFSET);
    localparam logic [IDX_W-1:0] FAR_WRAP  = IDX_W'(STATE_WORDS - SHIFT_OFFSET);

    localparam logic [31:0] TWIST_MATRIX  = 32'h9908_b0df;
    localparam logic [31:0] SEED_MULT     = 32'd1812433253;
    localparam logic [31:0] TEMPER_B      = 32'h9d2c_5680;
    localparam logic [31:0] TEMPER_C      = 32'hefc6_0000;
    localparam logic [31:0] UPPER_MASK    = 32'h8000_0000;
    localparam logic [31:0] LOWER_MASK    = 32'h7fff_ffff;
    localparam logic [31:0] AUTO_SEED_RST = 32'd5489;

    localparam logic CMD_DRAW = 1'b0;
    localparam logic CMD_SEED = 1'b1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SEED,
        ST_TWIST
    } t_state;

    // One step of the twist: upper bit from the current word, low part and
    // odd test from the next word.
    function automatic logic [31:0] twist_word(input logic [31:0] cur,
                                               input logic [31:0] nxt,
                                               input logic [31:0] far);
        logic [31:0] y;
        logic [31:0] w;
        y = (cur & UPPER_MASK) | (nxt & LOWER_MASK);
        w = far ^ (y >> 1);
        if (nxt[0]) begin
            w = w ^ TWIST_MATRIX;
        end
        return w;
    endfunction

    function automatic logic [31:0] temper(input logic [31:0] x);
        logic [31:0] s;
        s = x ^ (x >> 11);
        s = s ^ ((s << 7) & TEMPER_B);
        s = s ^ ((s << 15) & TEMPER_C);
        s = s ^ (s >> 18);
        return s;
    endfunction

endpackage

`default_nettype wire

/* hw/rtl/mersenne_twister_generator.sv */
// Top level of the 32-bit Mersenne Twister: control, seeding and draw path.
// Depends on mtg_pkg and two mtg_ram instances that mirror the state words.
`default_nettype none

// Usage
//   Command channel: a beat is taken at a rising edge with start high and busy
//   low. i_cmd selects a draw or a seed; i_seed_value is used by a seed only.
//   Result channel: o_valid is high for exactly one cycle with o_random_value,
//   the tempered word shifted right by one. The receiver cannot stall it.
//   Config: i_cfg_we writes i_cfg_wdata into auto_seed; write only while idle.
// Timing
//   Seed: busy while one state word is written per cycle by the
//   multiplier recurrence. No result beat.
//   Draw: busy in the twist state only; the result strobes in the cycle after
//   it, while the next command can already be taken. Draws alternate between
//   the idle and twist states, set by the registered read of the state memories.
//   A draw before any seed first runs the seed from auto_seed.
// Twist
//   Each draw twists the word at the read position from that word, the next
//   word and the word 397 ahead, writes it back and tempers it; two mirrored
//   memories give both neighbor words from one registered read.
// Reset: synchronous, active low: unseeded, position 0, auto_seed 5489.
//   The state memories hold no reset value and get no clearing pass.

module mersenne_twister_generator
    import mtg_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        start,
    output logic             busy,
    input  wire logic        i_cmd,
    input  wire logic [31:0] i_seed_value,
    output logic             o_valid,
    output logic [30:0]      o_random_value,
    input  wire logic        i_cfg_we,
    input  wire logic [31:0] i_cfg_wdata
);

    t_state             r_state,     n_state;
    logic [IDX_W-1:0]   r_idx,       n_idx;
    logic [IDX_W-1:0]   r_pos,       n_pos;
    logic [31:0]        r_prev,      n_prev;
    logic [31:0]        r_cur,       n_cur;
    logic               r_seeded,    n_seeded;
    logic               r_draw_pend, n_draw_pend;
    logic               r_valid,     n_valid;
    logic [30:0]        r_value,     n_value;
    logic [31:0]        r_auto_seed;

    logic               accept;
    logic [IDX_W-1:0]   nxt_addr;
    logic [IDX_W-1:0]   far_addr;
    logic [31:0]        nxt_word;
    logic [31:0]        far_word;
    logic [31:0]        twisted;
    logic [31:0]        tempered;
    logic [IDX_W-1:0]   idx_inc;
    logic [31:0]        seed_prod;
    logic               ram_we;
    logic [IDX_W-1:0]   ram_waddr;
    logic [31:0]        ram_wdata;

    assign accept = start && !busy;
    assign busy   = (r_state != ST_IDLE);

    // Read addresses follow the position; the words come back from the registered read in the next cycle.
    assign nxt_addr = (r_pos == IDX_LAST) ? '0 : r_pos + IDX_W'(1);
    assign far_addr = (r_pos < FAR_WRAP) ? r_pos + FAR_OFS : r_pos - FAR_WRAP;

    assign twisted  = twist_word(r_cur, nxt_word, far_word);
    assign tempered = temper(twisted);

    // Knuth recurrence for the fill: one multiply and add per word.
    assign idx_inc   = r_idx + IDX_W'(1);
    assign seed_prod = SEED_MULT * (r_prev ^ (r_prev >> 30));

    mtg_ram #(
        .WIDTH (32),
        .DEPTH (STATE_WORDS)
    ) u_ram_nxt (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (nxt_addr),
        .o_rdata (nxt_word)
    );

    mtg_ram #(
        .WIDTH (32),
        .DEPTH (STATE_WORDS)
    ) u_ram_far (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (far_addr),
        .o_rdata (far_word)
    );

    always_comb begin
        n_state     = r_state;
        n_idx       = r_idx;
        n_pos       = r_pos;
        n_prev      = r_prev;
        n_cur       = r_cur;
        n_seeded    = r_seeded;
        n_draw_pend = r_draw_pend;
        n_valid     = 1'b0;
        n_value     = r_value;
        ram_we      = 1'b0;
        ram_waddr   = r_pos;
        ram_wdata   = twisted;

        case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    if (i_cmd == CMD_SEED || !r_seeded) begin
                        // Load the seed and restart the fill at word 0.
                        n_prev      = (i_cmd == CMD_SEED) ? i_seed_value : r_auto_seed;
                        n_cur       = n_prev;
                        n_idx       = '0;
                        n_pos       = '0;
                        n_draw_pend = (i_cmd == CMD_DRAW);
                        n_state     = ST_SEED;
                    end else begin
                        n_state = ST_TWIST;
                    end
                end
            end
            ST_SEED: begin
                ram_we    = 1'b1;
                ram_waddr = r_idx;
                ram_wdata = r_prev;
                n_prev    = seed_prod + 32'(idx_inc);
                n_idx     = idx_inc;
                if (r_idx == IDX_LAST) begin
                    n_seeded    = 1'b1;
                    n_draw_pend = 1'b0;
                    n_state     = r_draw_pend ? ST_TWIST : ST_IDLE;
                end
            end
            ST_TWIST: begin
                // Write back the regenerated word and advance; hold the next
                // word as the current one for the following draw.
                ram_we  = 1'b1;
                n_valid = 1'b1;
                n_value = tempered[31:1];
                n_cur   = nxt_word;
                n_pos   = nxt_addr;
                n_state = ST_IDLE;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_pos       <= '0;
            r_seeded    <= 1'b0;
            r_draw_pend <= 1'b0;
            r_valid     <= 1'b0;
            r_auto_seed <= AUTO_SEED_RST;
        end else begin
            r_state     <= n_state;
            r_pos       <= n_pos;
            r_seeded    <= n_seeded;
            r_draw_pend <= n_draw_pend;
            r_valid     <= n_valid;
            if (i_cfg_we) begin
                r_auto_seed <= i_cfg_wdata;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_idx   <= n_idx;
        r_prev  <= n_prev;
        r_cur   <= n_cur;
        r_value <= n_value;
    end

    assign o_valid        = r_valid;
    assign o_random_value = r_value;

`ifndef SYNTHESIS
    a_valid_after_twist: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid |-> $past(r_state == ST_TWIST))
        else $error("result beat without a preceding twist");

    a_pos_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pos <= IDX_LAST)
        else $error("read position out of range");

    a_twist_needs_seed: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_TWIST) |-> r_seeded)
        else $error("twist on unseeded state");

    a_seed_cmd_fills: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && i_cmd == CMD_SEED) |=> (r_state == ST_SEED && r_idx == '0))
        else $error("seed beat did not start the fill");
`endif

endmodule

`default_nettype wire

/* hw/rtl/mtg_ram.sv */
// Generic single-write, single-read RAM with a registered read port.
// No dependencies; no shared items from mtg_pkg are needed here.
`default_nettype none

module mtg_ram #(
    parameter int unsigned WIDTH = 32,
    parameter int unsigned DEPTH = 624
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

/* bench/mersenne_twister_generator_test.sv */
// Self-checking bench for mersenne_twister_generator: seed and draw beats against
// an in-bench twister predictor held in a small scoreboard class.
// Depends on mtg_pkg (sizes, command codes, reset seed) and the generator RTL.

module mersenne_twister_generator_test;
    import mtg_pkg::*;

    localparam int     CLK_PERIOD    = 8;
    localparam int     RESET_CYCLES  = 7;
    // Covers the draw result that strobes in the cycle busy drops, with margin.
    localparam int     SETTLE_CYCLES = 8;
    // Hard limit for the run, far above the worst case even with every seed and long gap.
    localparam longint RUN_LIMIT     = 64'd16_000_000;

    // Generator constants, kept apart from the package so the predictor
    // does not share a typo with the RTL.
    localparam logic [31:0] K_TWIST     = 32'h9908_b0df;
    localparam logic [31:0] K_SEED_MULT = 32'd1812433253;
    localparam logic [31:0] K_TEMPER_B  = 32'h9d2c_5680;
    localparam logic [31:0] K_TEMPER_C  = 32'hefc6_0000;
    localparam logic [31:0] K_UPPER     = 32'h8000_0000;
    localparam logic [31:0] K_LOWER     = 32'h7fff_ffff;

    // Predicts every draw from its own copy of the state words and holds the
    // draws still owed by the block, oldest first.
    class twister_scoreboard;
        bit [31:0] mt_words [STATE_WORDS];
        bit        seeded;
        int        words_remaining;
        int        next_index;
        bit [31:0] power_on_seed;
        bit [30:0] pending_draws [$];
        int        failures;

        function new();
            seeded          = 1'b0;
            words_remaining = 0;
            next_index      = 0;
            power_on_seed   = AUTO_SEED_RST;
            failures        = 0;
        endfunction

        function void set_auto_seed(bit [31:0] value);
            power_on_seed = value;
        endfunction

        function int outstanding();
            return pending_draws.size();
        endfunction

        // Regenerate all words at once; the odd test uses the next word.
        function void twist_all();
            bit [31:0] nxt;
            bit [31:0] far_word;
            bit [31:0] y;
            bit [31:0] w;
            for (int k = 0; k < STATE_WORDS; k++) begin
                nxt      = mt_words[(k + 1) % STATE_WORDS];
                far_word = mt_words[(k + SHIFT_OFFSET) % STATE_WORDS];
                y        = (mt_words[k] & K_UPPER) | (nxt & K_LOWER);
                w        = far_word ^ (y >> 1);
                if (nxt[0]) begin
                    w = w ^ K_TWIST;
                end
                mt_words[k] = w;
            end
            words_remaining = STATE_WORDS;
            next_index      = 0;
        endfunction

        function void rebuild_from(bit [31:0] seed);
            bit [31:0] prev;
            mt_words[0] = seed;
            for (int k = 1; k < STATE_WORDS; k++) begin
                prev        = mt_words[k-1];
                mt_words[k] = K_SEED_MULT * (prev ^ (prev >> 30)) + 32'(k);
            end
            twist_all();
            seeded = 1'b1;
        endfunction

        function bit [30:0] next_tempered();
            bit [31:0] s;
            int        p;
            if (words_remaining == 0) begin
                twist_all();
            end
            words_remaining--;
            p = next_index;
            if (p >= STATE_WORDS) begin
                p = 0;
            end
            s          = mt_words[p];
            next_index = p + 1;
            s = s ^ (s >> 11);
            s = s ^ ((s << 7) & K_TEMPER_B);
            s = s ^ ((s << 15) & K_TEMPER_C);
            s = s ^ (s >> 18);
            return s[31:1];
        endfunction

        function void note_beat(logic cmd, logic [31:0] seed);
            if (cmd == CMD_SEED) begin
                rebuild_from(seed);
            end else begin
                if (!seeded) begin
                    rebuild_from(power_on_seed);
                end
                pending_draws.push_back(next_tempered());
            end
        endfunction

        function void check_draw(logic [30:0] actual);
            bit [30:0] want;
            if (pending_draws.size() == 0) begin
                $error("random_value: no draw expected, actual %h", actual);
                failures++;
                return;
            end
            want = pending_draws.pop_front();
            if (actual !== want) begin
                $error("random_value: expected %h, actual %h", want, actual);
                failures++;
            end
        endfunction
    endclass

    logic        i_clk        = 1'b0;
    logic        i_rst_n      = 1'b0;
    logic        start        = 1'b0;
    logic        busy;
    logic        i_cmd        = CMD_DRAW;
    logic [31:0] i_seed_value = '0;
    logic        o_valid;
    logic [30:0] o_random_value;
    logic        i_cfg_we     = 1'b0;
    logic [31:0] i_cfg_wdata  = '0;

    twister_scoreboard board;

    always #(CLK_PERIOD/2) i_clk = ~i_clk;

    mersenne_twister_generator u_top (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .busy           (busy),
        .i_cmd          (i_cmd),
        .i_seed_value   (i_seed_value),
        .o_valid        (o_valid),
        .o_random_value (o_random_value),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_wdata    (i_cfg_wdata)
    );

    // Take every result beat at the edge that ends its strobe cycle; the block
    // cannot be held off, so there is nothing to drive on this side.
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid) begin
            board.check_draw(o_random_value);
        end
    end

    // Hold a command beat until an edge sees start high and busy low, then
    // tell the predictor. Start stays high; the caller decides whether to drop it.
    task automatic issue_beat(input logic cmd, input logic [31:0] seed);
        start        <= 1'b1;
        i_cmd        <= cmd;
        i_seed_value <= seed;
        do begin
            @(posedge i_clk);
        end while (busy);
        board.note_beat(cmd, seed);
    endtask

    // Drop start for a gap of n; zero keeps back-to-back beats.
    task automatic idle_sender(input int n);
        if (n > 0) begin
            start <= 1'b0;
            repeat (n) @(posedge i_clk);
        end
    endtask

    // Drop start and hold off until every owed draw has come back.
    task automatic wait_drained();
        start <= 1'b0;
        @(posedge i_clk);
        while (board.outstanding() != 0) @(posedge i_clk);
    endtask

    // Write auto_seed only with the block idle: drained, not busy, and settled,
    // since a seed beat leaves the block working with no result owed.
    task automatic reload_auto_seed(input logic [31:0] value);
        wait_drained();
        while (busy) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= value;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        board.set_auto_seed(value);
    endtask

    // Mostly no gap, some short, a few long; calm stretches never idle.
    function automatic int pick_gap(input bit calm);
        int r;
        if (calm) begin
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 60) begin
            return 0;
        end else if (r < 92) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(10, 60);
    endfunction

    // Favor the seed extremes now and then; the rest is full-range noise.
    function automatic logic [31:0] pick_seed();
        int r;
        r = $urandom_range(0, 9);
        if (r == 0) begin
            return 32'h0000_0000;
        end else if (r == 1) begin
            return 32'hffff_ffff;
        end
        return $urandom();
    endfunction

    initial begin
        int  n_draws;
        bit  calm;
        board = new();
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Draw before any seed: the block seeds itself from the reset auto_seed.
        // The seed field is ignored on draws, so drive its extremes here.
        issue_beat(CMD_DRAW, 32'hffff_ffff);
        issue_beat(CMD_DRAW, 32'h0000_0000);
        idle_sender(2);
        issue_beat(CMD_DRAW, $urandom());
        idle_sender(1);

        // Explicit seeds at the extremes and the top bit, each followed by one or two draws.
        issue_beat(CMD_SEED, 32'h0000_0000);
        issue_beat(CMD_DRAW, 32'h0000_0000);
        issue_beat(CMD_DRAW, 32'hffff_ffff);
        issue_beat(CMD_SEED, 32'hffff_ffff);
        idle_sender(3);
        issue_beat(CMD_DRAW, $urandom());
        issue_beat(CMD_DRAW, $urandom());
        issue_beat(CMD_SEED, 32'h8000_0000);
        issue_beat(CMD_DRAW, $urandom());

        // Back-to-back seeds: only the last one counts.
        issue_beat(CMD_SEED, 32'h0000_0001);
        issue_beat(CMD_SEED, AUTO_SEED_RST);
        issue_beat(CMD_DRAW, $urandom());
        idle_sender(1);
        issue_beat(CMD_DRAW, $urandom());
        issue_beat(CMD_SEED, 32'haaaa_aaaa);
        issue_beat(CMD_DRAW, $urandom());
        issue_beat(CMD_SEED, 32'h5555_5555);
        issue_beat(CMD_DRAW, $urandom());

        reload_auto_seed(32'hffff_ffff);

        // One long run past the end of the 624 words, so the state gets
        // regenerated mid-stream. Mix calm and gappy stretches, picked at random every 50 draws.
        issue_beat(CMD_SEED, pick_seed());
        n_draws = $urandom_range(626, 640);
        calm    = 1'b0;
        for (int k = 0; k < n_draws; k++) begin
            if (k % 50 == 0) begin
                calm = ($urandom_range(0, 2) == 0);
            end
            issue_beat(CMD_DRAW, $urandom());
            idle_sender(pick_gap(calm));
        end

        // Short mixed phases, a new auto_seed between each.
        for (int phase = 0; phase < 6; phase++) begin
            case (phase)
                0:       reload_auto_seed(32'h0000_0000);
                1:       reload_auto_seed(32'hffff_ffff);
                2:       reload_auto_seed(AUTO_SEED_RST);
                default: reload_auto_seed($urandom());
            endcase
            calm = (phase % 3 == 1);
            for (int k = 0; k < 4; k++) begin
                if ($urandom_range(0, 99) < 15) begin
                    issue_beat(CMD_SEED, pick_seed());
                end else begin
                    issue_beat(CMD_DRAW, $urandom());
                end
                if ($urandom_range(0, 19) == 0) begin
                    wait_drained();
                end else begin
                    idle_sender(pick_gap(calm));
                end
            end
        end

        // Let the last beats finish, then judge.
        wait_drained();
        while (busy) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (board.failures == 0 && board.outstanding() == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

    // Hard stop in case the block stops answering or stays busy.
    initial begin
        #(RUN_LIMIT);
        $display("Mismatches found");
        $finish;
    end

endmodule
